@@ rtl/assert_macros.svh @@
// Assertion macros used by the ALU top level, cpu_alu_with_flags_core.
// No dependencies; each macro expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

@@ rtl/calu_pkg.sv @@
// Package for the 8-bit CPU ALU: operation codes, flag positions and item types.
// No dependencies; used by calu_exec and cpu_alu_with_flags_core.
package calu_pkg;

    localparam logic [4:0] CMD_ADD   = 5'd0;
    localparam logic [4:0] CMD_ADC   = 5'd1;
    localparam logic [4:0] CMD_SUB   = 5'd2;
    localparam logic [4:0] CMD_SBC   = 5'd3;
    localparam logic [4:0] CMD_CP    = 5'd4;
    localparam logic [4:0] CMD_AND   = 5'd5;
    localparam logic [4:0] CMD_OR    = 5'd6;
    localparam logic [4:0] CMD_XOR   = 5'd7;
    localparam logic [4:0] CMD_INC   = 5'd8;
    localparam logic [4:0] CMD_DEC   = 5'd9;
    localparam logic [4:0] CMD_BIT   = 5'd10;
    localparam logic [4:0] CMD_RL    = 5'd11;
    localparam logic [4:0] CMD_RR    = 5'd12;
    localparam logic [4:0] CMD_RLC   = 5'd13;
    localparam logic [4:0] CMD_RRC   = 5'd14;
    localparam logic [4:0] CMD_SLA   = 5'd15;
    localparam logic [4:0] CMD_SRA   = 5'd16;
    localparam logic [4:0] CMD_SRL   = 5'd17;
    localparam logic [4:0] CMD_SWAP  = 5'd18;
    localparam logic [4:0] CMD_ADDW  = 5'd19;
    localparam logic [4:0] CMD_ADDSP = 5'd20;

    // Bit positions inside the four-bit flag word.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [7:0]  acc_in;
        logic [3:0]  flags_in;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [2:0]  bit_index;
    } item_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags;
    } res_t;

endpackage

@@ rtl/calu_exec.sv @@
// Combinational execute logic of the ALU: one operation and its new flags.
// Depends on calu_pkg for operation codes, flag positions and item types.
module calu_exec (
    input  calu_pkg::item_t item,
    output calu_pkg::res_t  res
);

    logic [7:0]  acc;
    logic [7:0]  r8;
    logic [7:0]  n8;
    logic        cin;
    logic        use_c;
    logic [8:0]  add9;
    logic [4:0]  add_h;
    logic [8:0]  sub9;
    logic [4:0]  sub_h;
    logic [16:0] addw17;
    logic [12:0] addw_h;
    logic [15:0] sp16;
    logic [4:0]  sp_h;
    logic [8:0]  sp_c;
    logic [7:0]  inc8;
    logic [7:0]  dec8;

    assign acc   = item.acc_in;
    assign r8    = item.value_a[7:0];
    assign n8    = item.value_b[7:0];
    assign cin   = item.flags_in[calu_pkg::FLAG_C];
    assign use_c = ((item.cmd == calu_pkg::CMD_ADC) || (item.cmd == calu_pkg::CMD_SBC)) & cin;

    // Shared adders; the carry-in is used only by adc and sbc.
    assign add9   = {1'b0, acc} + {1'b0, n8} + {8'd0, use_c};
    assign add_h  = {1'b0, acc[3:0]} + {1'b0, n8[3:0]} + {4'd0, use_c};
    assign sub9   = {1'b0, acc} - {1'b0, n8} - {8'd0, use_c};
    assign sub_h  = {1'b0, acc[3:0]} - {1'b0, n8[3:0]} - {4'd0, use_c};
    assign addw17 = {1'b0, item.value_a} + {1'b0, item.value_b};
    assign addw_h = {1'b0, item.value_a[11:0]} + {1'b0, item.value_b[11:0]};
    assign sp16   = item.value_a + {{8{n8[7]}}, n8};
    assign sp_h   = {1'b0, item.value_a[3:0]} + {1'b0, n8[3:0]};
    assign sp_c   = {1'b0, item.value_a[7:0]} + {1'b0, n8};
    assign inc8   = r8 + 8'd1;
    assign dec8   = r8 - 8'd1;

    always_comb
    begin
        logic [7:0] b8;
        logic       z;
        logic       n;
        logic       h;
        logic       c;
        logic       byte_op;

        b8      = acc;
        n       = 1'b0;
        h       = 1'b0;
        c       = 1'b0;
        byte_op = 1'b1;
        res.result = {8'd0, acc};
        res.flags  = item.flags_in;
        case (item.cmd)
            calu_pkg::CMD_ADD, calu_pkg::CMD_ADC:
            begin
                b8 = add9[7:0];
                h  = add_h[4];
                c  = add9[8];
            end
            calu_pkg::CMD_SUB, calu_pkg::CMD_SBC, calu_pkg::CMD_CP:
            begin
                b8 = sub9[7:0];
                n  = 1'b1;
                h  = sub_h[4];
                c  = sub9[8];
            end
            calu_pkg::CMD_AND:
            begin
                b8 = acc & n8;
                h  = 1'b1;
            end
            calu_pkg::CMD_OR:  b8 = acc | n8;
            calu_pkg::CMD_XOR: b8 = acc ^ n8;
            calu_pkg::CMD_INC:
            begin
                b8 = inc8;
                h  = (r8[3:0] == 4'hf);
                c  = cin;
            end
            calu_pkg::CMD_DEC:
            begin
                b8 = dec8;
                n  = 1'b1;
                h  = (r8[3:0] == 4'h0);
                c  = cin;
            end
            calu_pkg::CMD_BIT:
            begin
                b8 = r8;
                h  = 1'b1;
                c  = cin;
            end
            calu_pkg::CMD_RL:
            begin
                b8 = {r8[6:0], cin};
                c  = r8[7];
            end
            calu_pkg::CMD_RR:
            begin
                b8 = {cin, r8[7:1]};
                c  = r8[0];
            end
            calu_pkg::CMD_RLC:
            begin
                b8 = {r8[6:0], r8[7]};
                c  = r8[7];
            end
            calu_pkg::CMD_RRC:
            begin
                b8 = {r8[0], r8[7:1]};
                c  = r8[0];
            end
            calu_pkg::CMD_SLA:
            begin
                b8 = {r8[6:0], 1'b0};
                c  = r8[7];
            end
            calu_pkg::CMD_SRA:
            begin
                b8 = {r8[7], r8[7:1]};
                c  = r8[0];
            end
            calu_pkg::CMD_SRL:
            begin
                b8 = {1'b0, r8[7:1]};
                c  = r8[0];
            end
            calu_pkg::CMD_SWAP: b8 = {r8[3:0], r8[7:4]};
            default: byte_op = 1'b0;
        endcase

        // The bit test sets Z from the selected bit, the other byte operations from the byte.
        if (item.cmd == calu_pkg::CMD_BIT)
        begin
            z = ~r8[item.bit_index];
        end
        else
        begin
            z = (b8 == 8'd0);
        end

        if (byte_op)
        begin
            // Compare leaves the accumulator as it was.
            res.result = (item.cmd == calu_pkg::CMD_CP) ? {8'd0, acc} : {8'd0, b8};
            res.flags  = {z, n, h, c};
        end
        else if (item.cmd == calu_pkg::CMD_ADDW)
        begin
            res.result = addw17[15:0];
            res.flags  = {item.flags_in[calu_pkg::FLAG_Z], 1'b0, addw_h[12], addw17[16]};
        end
        else if (item.cmd == calu_pkg::CMD_ADDSP)
        begin
            res.result = sp16;
            res.flags  = {1'b0, 1'b0, sp_h[4], sp_c[8]};
        end
    end

endmodule

@@ rtl/cpu_alu_with_flags_core.sv @@
// Top level of the 8-bit CPU ALU with Z/N/H/C flags.
// done is registered from the stage-one valid bit: it rises in the cycle after stage one takes an operation in.
// Throughput: one operation per cycle; busy is always low, so start may stay high.
// The result and flags stay on the ports until the next result is loaded; done marks when they are new.
// Reset (rst_n, asynchronous, active low) clears the valid bits of both stages.
// Depends on calu_pkg, calu_exec and assert_macros.svh.
module cpu_alu_with_flags_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  cmd,
    input  logic [7:0]  acc_in,
    input  logic [3:0]  flags_in,
    input  logic [15:0] value_a,
    input  logic [15:0] value_b,
    input  logic [2:0]  bit_index,
    output logic        done,
    output logic [15:0] result,
    output logic [3:0]  flags_out
);

`include "assert_macros.svh"

    // Stage one holds the operation as it was transferred in. Stage two
    // holds the finished result. Each stage has a valid bit that reset
    // clears; the payload registers are loaded without reset.
    logic            in_vld_reg;
    logic            in_vld_next;
    calu_pkg::item_t item_reg;
    calu_pkg::item_t item_next;
    calu_pkg::res_t  exec_res;
    logic            out_vld_reg;
    calu_pkg::res_t  res_reg;

    // The datapath is shallow enough that every stage advances every
    // cycle, so the block never has to hold off a new transfer.
    assign busy = 1'b0;

    always_comb
    begin
        in_vld_next = start & ~busy;
        item_next   = item_reg;
        if (in_vld_next)
        begin
            item_next.cmd       = cmd;
            item_next.acc_in    = acc_in;
            item_next.flags_in  = flags_in;
            item_next.value_a   = value_a;
            item_next.value_b   = value_b;
            item_next.bit_index = bit_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (in_vld_reg)
        begin
            res_reg <= exec_res;
        end
    end

    // All arithmetic, logic, shift and flag work sits in this one block.
    calu_exec u_exec (
        .item (item_reg),
        .res  (exec_res)
    );

    assign done      = out_vld_reg;
    assign result    = res_reg.result;
    assign flags_out = res_reg.flags;

    `ASSERT_NEXT(a_start_loads, start, in_vld_reg)
    `ASSERT_NEXT(a_stage_done, in_vld_reg, done)
    `ASSERT_NEXT(a_no_spurious_done, !in_vld_reg, !done)
    `ASSERT_NEXT(a_cp_keeps_acc, in_vld_reg && (item_reg.cmd == calu_pkg::CMD_CP), result == {8'd0, $past(item_reg.acc_in)})

endmodule
